// ===== src/phase_sync_blink_tracker_defines.svh =====
// Assertion macros used by the checker of this block.
// Both macros sample on the rising edge of i_clk and are disabled while i_rst_n is low.
`ifndef PHASE_SYNC_BLINK_TRACKER_DEFINES_SVH
`define PHASE_SYNC_BLINK_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSBT_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSBT_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/psbt_pkg.sv =====
`timescale 1ns / 1ps

package psbt_pkg;

    localparam int CFG_W      = 12;
    localparam int AIR_W      = 8;
    localparam int PH_W       = 12;
    localparam int CYC_W      = 13;
    localparam int EL_W       = 8;
    localparam int HDR_W      = 16;
    localparam int RXP_W      = 16;
    localparam int ADDR_W     = 5;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;
    localparam int TBL_DEPTH  = 256;
    localparam int TBL_AW     = 8;
    localparam int RED_STEPS  = 13;
    localparam int PULL_SHIFT = 2;

    localparam logic [HDR_W-1:0] SYNC_HEADER = 16'hAA55;
    localparam logic [PH_W-1:0]  AGE_MAX     = 12'hFFF;
    localparam logic [CYC_W-1:0] CYC_ZERO_LEN = 13'h1000;

    localparam logic [CFG_W-1:0] RST_CYCLE      = 12'd900;
    localparam logic [CFG_W-1:0] RST_LAMP_ON    = 12'd100;
    localparam logic [CFG_W-1:0] RST_SEND_START = 12'd450;
    localparam logic [CFG_W-1:0] RST_SEND_WIN   = 12'd50;
    localparam logic [AIR_W-1:0] RST_AIR_DELAY  = 8'd6;

    typedef enum logic [2:0] {
        REG_CYCLE      = 3'd0,
        REG_LAMP_ON    = 3'd1,
        REG_SEND_START = 3'd2,
        REG_SEND_WIN   = 3'd3,
        REG_AIR_DELAY  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic              wrap;
        logic [EL_W-1:0]   rem;
    } t_tbl_entry;

endpackage

// ===== src/phase_sync_blink_tracker.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                    | Contents
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | one control loop pass
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | lamp, sync packet and phase
// apb       | in        | psel/penable/pwrite, pready  | five configuration registers
//
// One item is taken per clock unless a table build or a stalled output holds it off.
// The output register lets a new item enter while the previous result waits.
// After reset and after every write to cycle_length_ms or air_delay_ms, a table
// build runs with s_axis_tready low; it also reduces the phase into the new cycle.
// A stalled output holds the input register, so s_axis_tready drops behind it.

module phase_sync_blink_tracker
    import psbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // elapsed_ms[7:0], rx_header[23:8], rx_phase[39:24]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // rx_present[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // lamp_lit[0], send_phase[12:1], current_phase[24:13], zero[31:25]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // send_now[0]
    output logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam logic signed [CYC_W:0] PULL_BIAS = (CYC_W+1)'((1 << PULL_SHIFT) - 1);

    // Configuration registers.
    logic [CFG_W-1:0] r_cycle, n_cycle;
    logic [CFG_W-1:0] r_lamp_on, n_lamp_on;
    logic [CFG_W-1:0] r_send_start, n_send_start;
    logic [CFG_W-1:0] r_send_win, n_send_win;
    logic [AIR_W-1:0] r_air, n_air;

    // Block state.
    logic [PH_W-1:0]  r_phase, n_phase;
    logic             r_lamp, n_lamp;
    logic [PH_W-1:0]  r_age, n_age;
    logic             r_sent, n_sent;
    logic             r_wrap_pend, n_wrap_pend;

    // Table build.
    logic              r_fill_busy, n_fill_busy;
    logic [TBL_AW-1:0] r_fill_idx, n_fill_idx;
    logic [EL_W-1:0]   r_fill_rem, n_fill_rem;
    logic [EL_W-1:0]   r_air_rem, n_air_rem;
    t_tbl_entry        r_tbl [TBL_DEPTH];
    t_tbl_entry        r_in_tbl;

    // Input and output registers.
    logic              r_in_valid, n_in_valid;
    logic [EL_W-1:0]   r_in_elapsed;
    logic              r_in_present;
    logic [HDR_W-1:0]  r_in_header;
    logic [RXP_W-1:0]  r_in_rx_phase;
    logic              r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_send, n_out_send;

    logic              w_cfg_wr;
    t_reg_idx          w_reg_idx;
    logic [CYC_W-1:0]  w_cyc;
    logic              w_adv;
    logic              w_in_accept;

    logic [EL_W:0]     w_rem_inc;
    t_tbl_entry        w_fill_entry;
    logic [3:0]        w_red_shift;
    logic [24:0]       w_red_div;
    logic              w_red_ge;

    logic [CYC_W-1:0]  w_sum;
    logic              w_wrap;
    logic [PH_W-1:0]   w_ph1;
    logic [CYC_W-1:0]  w_age_sum;
    logic [PH_W-1:0]   w_age1;
    logic              w_lamp_a, w_lamp_b;
    logic [PH_W-1:0]   w_age_a, w_age_b;
    logic              w_sent_a;
    logic              w_tx;
    logic [CYC_W-1:0]  w_sp_sum;
    logic [PH_W-1:0]   w_sp;
    logic              w_rx;
    logic signed [CYC_W:0] w_cyc_s, w_half, w_d0, w_d1, w_d2, w_q, w_np0, w_np1, w_np2;
    logic [PH_W-1:0]   w_ph_out;
    logic              w_lamp_out;

    assign pready        = 1'b1;
    assign w_cfg_wr      = psel & penable & pwrite & pready;
    assign w_reg_idx     = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cyc         = (r_cycle == '0) ? CYC_ZERO_LEN : {1'b0, r_cycle};
    assign w_adv         = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_fill_busy & (~r_in_valid | w_adv);
    assign w_in_accept   = s_axis_tvalid & s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_send;

    always_comb begin
        case (w_reg_idx)
            REG_CYCLE:      prdata = {20'd0, r_cycle};
            REG_LAMP_ON:    prdata = {20'd0, r_lamp_on};
            REG_SEND_START: prdata = {20'd0, r_send_start};
            REG_SEND_WIN:   prdata = {20'd0, r_send_win};
            REG_AIR_DELAY:  prdata = {24'd0, r_air};
            default:        prdata = '0;
        endcase
    end

    // Table build: entry e holds e mod cycle and whether e reaches the cycle.
    assign w_rem_inc         = {1'b0, r_fill_rem} + 1'b1;
    assign w_fill_entry.rem  = r_fill_rem;
    assign w_fill_entry.wrap = {{(CYC_W-TBL_AW){1'b0}}, r_fill_idx} >= w_cyc;
    assign w_red_shift       = 4'(RED_STEPS - 1) - r_fill_idx[3:0];
    assign w_red_div         = {12'd0, w_cyc} << w_red_shift;
    assign w_red_ge          = {13'd0, r_phase} >= w_red_div;

    // Advance.
    assign w_sum     = {1'b0, r_phase} + {{(CYC_W-EL_W){1'b0}}, r_in_tbl.rem};
    assign w_ph1     = (w_sum >= w_cyc) ? PH_W'(w_sum - w_cyc) : w_sum[PH_W-1:0];
    assign w_wrap    = r_in_tbl.wrap | (w_sum >= w_cyc) | r_wrap_pend;
    assign w_age_sum = {1'b0, r_age} + {{(CYC_W-EL_W){1'b0}}, r_in_elapsed};
    assign w_age1    = w_age_sum[PH_W] ? AGE_MAX : w_age_sum[PH_W-1:0];
    assign w_lamp_a  = w_wrap | r_lamp;
    assign w_age_a   = w_wrap ? '0 : w_age1;
    assign w_sent_a  = w_wrap ? 1'b0 : r_sent;

    // On-time and on-window.
    always_comb begin
        w_lamp_b = w_lamp_a;
        w_age_b  = w_age_a;
        if (w_lamp_a) begin
            if (w_age_a >= r_lamp_on) begin
                w_lamp_b = 1'b0;
            end
        end else if (w_ph1 < r_lamp_on) begin
            w_lamp_b = 1'b1;
            w_age_b  = '0;
        end
    end

    // Transmit window.
    assign w_tx     = ~w_sent_a & (w_ph1 >= r_send_start) &
                      ({1'b0, w_ph1} < ({1'b0, r_send_start} + {1'b0, r_send_win}));
    assign w_sp_sum = {1'b0, w_ph1} + {{(CYC_W-EL_W){1'b0}}, r_air_rem};
    assign w_sp     = (w_sp_sum >= w_cyc) ? PH_W'(w_sp_sum - w_cyc) : w_sp_sum[PH_W-1:0];

    // Receive and pull.
    assign w_rx    = r_in_present & (r_in_header == SYNC_HEADER) &
                     ({{(RXP_W-CYC_W){1'b0}}, w_cyc} > r_in_rx_phase);
    assign w_cyc_s = $signed({1'b0, w_cyc});
    assign w_half  = $signed({2'b0, w_cyc[CYC_W-1:1]});
    assign w_d0    = $signed({2'b0, r_in_rx_phase[PH_W-1:0]}) - $signed({2'b0, w_ph1});
    assign w_d1    = (w_d0 > w_half) ? (w_d0 - w_cyc_s) : w_d0;
    assign w_d2    = (w_d1 < -w_half) ? (w_d1 + w_cyc_s) : w_d1;
    assign w_q     = $signed(w_d2 + (w_d2[CYC_W] ? PULL_BIAS : '0)) >>> PULL_SHIFT;
    assign w_np0   = $signed({2'b0, w_ph1}) + w_q;
    assign w_np1   = (w_np0 < 0) ? (w_np0 + w_cyc_s) : w_np0;
    assign w_np2   = (w_np1 >= w_cyc_s) ? (w_np1 - w_cyc_s) : w_np1;

    assign w_ph_out   = w_rx ? w_np2[PH_W-1:0] : w_ph1;
    assign w_lamp_out = w_tx | w_rx | w_lamp_b;

    always_comb begin
        n_cycle      = r_cycle;
        n_lamp_on    = r_lamp_on;
        n_send_start = r_send_start;
        n_send_win   = r_send_win;
        n_air        = r_air;
        n_phase      = r_phase;
        n_lamp       = r_lamp;
        n_age        = r_age;
        n_sent       = r_sent;
        n_wrap_pend  = r_wrap_pend;
        n_fill_busy  = r_fill_busy;
        n_fill_idx   = r_fill_idx;
        n_fill_rem   = r_fill_rem;
        n_air_rem    = r_air_rem;
        n_in_valid   = r_in_valid;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_send   = r_out_send;

        if (r_fill_busy) begin
            n_fill_idx = r_fill_idx + 1'b1;
            n_fill_rem = ({{(CYC_W-EL_W-1){1'b0}}, w_rem_inc} == w_cyc) ? '0
                                                                       : w_rem_inc[EL_W-1:0];
            if (r_fill_idx == r_air) begin
                n_air_rem = r_fill_rem;
            end
            if ((r_fill_idx < TBL_AW'(RED_STEPS)) && w_red_ge) begin
                n_phase     = PH_W'({13'd0, r_phase} - w_red_div);
                n_wrap_pend = 1'b1;
            end
            if (r_fill_idx == TBL_AW'(TBL_DEPTH - 1)) begin
                n_fill_busy = 1'b0;
            end
        end

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_adv) begin
            n_phase     = w_ph_out;
            n_lamp      = w_lamp_out;
            n_age       = (w_tx | w_rx) ? '0 : w_age_b;
            n_sent      = w_tx | w_sent_a;
            n_wrap_pend = 1'b0;
            n_out_valid = 1'b1;
            n_out_send  = w_tx;
            n_out_data  = {7'd0, w_ph_out, (w_tx ? w_sp : {PH_W{1'b0}}), w_lamp_out};
            n_in_valid  = 1'b0;
        end

        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end

        if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_CYCLE: begin
                    n_cycle     = pwdata[CFG_W-1:0];
                    n_fill_busy = 1'b1;
                    n_fill_idx  = '0;
                    n_fill_rem  = '0;
                end
                REG_LAMP_ON:    n_lamp_on    = pwdata[CFG_W-1:0];
                REG_SEND_START: n_send_start = pwdata[CFG_W-1:0];
                REG_SEND_WIN:   n_send_win   = pwdata[CFG_W-1:0];
                REG_AIR_DELAY: begin
                    n_air       = pwdata[AIR_W-1:0];
                    n_fill_busy = 1'b1;
                    n_fill_idx  = '0;
                    n_fill_rem  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle      <= RST_CYCLE;
            r_lamp_on    <= RST_LAMP_ON;
            r_send_start <= RST_SEND_START;
            r_send_win   <= RST_SEND_WIN;
            r_air        <= RST_AIR_DELAY;
            r_phase      <= '0;
            r_lamp       <= 1'b0;
            r_age        <= '0;
            r_sent       <= 1'b0;
            r_wrap_pend  <= 1'b0;
            r_fill_busy  <= 1'b1;
            r_fill_idx   <= '0;
            r_fill_rem   <= '0;
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cycle      <= n_cycle;
            r_lamp_on    <= n_lamp_on;
            r_send_start <= n_send_start;
            r_send_win   <= n_send_win;
            r_air        <= n_air;
            r_phase      <= n_phase;
            r_lamp       <= n_lamp;
            r_age        <= n_age;
            r_sent       <= n_sent;
            r_wrap_pend  <= n_wrap_pend;
            r_fill_busy  <= n_fill_busy;
            r_fill_idx   <= n_fill_idx;
            r_fill_rem   <= n_fill_rem;
            r_in_valid   <= n_in_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_air_rem  <= n_air_rem;
        r_out_data <= n_out_data;
        r_out_send <= n_out_send;
        if (w_in_accept) begin
            r_in_elapsed  <= s_axis_tdata[EL_W-1:0];
            r_in_header   <= s_axis_tdata[EL_W+HDR_W-1:EL_W];
            r_in_rx_phase <= s_axis_tdata[S_TDATA_W-1:EL_W+HDR_W];
            r_in_present  <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fill_busy) begin
            r_tbl[r_fill_idx] <= w_fill_entry;
        end
        if (w_in_accept) begin
            r_in_tbl <= r_tbl[s_axis_tdata[EL_W-1:0]];
        end
    end

endmodule

// ===== src/psbt_checker.sv =====
`timescale 1ns / 1ps
`include "phase_sync_blink_tracker_defines.svh"

module psbt_checker
    import psbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tready,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr
);

    logic                 w_out_stall;
    logic                 w_out_plain;
    logic                 w_out_sent;
    logic [2:0]           w_reg_sel;
    logic                 w_rebuild_wr;
    logic [M_TDATA_W+1:0] w_out_word;

    assign w_out_stall  = m_axis_tvalid & ~m_axis_tready;
    assign w_out_plain  = m_axis_tvalid & ~m_axis_tuser;
    assign w_out_sent   = m_axis_tvalid & m_axis_tuser;
    assign w_reg_sel    = paddr[ADDR_W-1:2];
    assign w_rebuild_wr = psel & penable & pwrite &
                          ((w_reg_sel == REG_CYCLE) || (w_reg_sel == REG_AIR_DELAY));
    assign w_out_word   = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    `PSBT_CHECK_NEXT(a_out_hold, w_out_stall, $stable(w_out_word), "held result changed")
    `PSBT_CHECK(a_no_send_zero, w_out_plain, m_axis_tdata[12:1] == 12'd0, "send_phase not zero")
    `PSBT_CHECK(a_send_lights, w_out_sent, m_axis_tdata[0], "lamp dark on a sent packet")
    `PSBT_CHECK_NEXT(a_rebuild_stall, w_rebuild_wr, !s_axis_tready, "input taken in rebuild")

endmodule

bind phase_sync_blink_tracker psbt_checker u_psbt_checker (.*);

// ===== test/phase_sync_blink_tracker_checker.sv =====
`timescale 1ns / 1ps

module phase_sync_blink_tracker_checker
    import psbt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    input  logic [31:0]           prdata,
    input  logic                  pready,
    output int                    o_errors,
    output int                    o_pending
);

    typedef struct packed {
        logic            lamp_lit;
        logic            send_now;
        logic [PH_W-1:0] send_phase;
        logic [PH_W-1:0] current_phase;
    } t_blink_out;

    logic [CFG_W-1:0] cycle_reg;
    logic [CFG_W-1:0] lamp_on_reg;
    logic [CFG_W-1:0] start_reg;
    logic [CFG_W-1:0] window_reg;
    logic [AIR_W-1:0] delay_reg;

    logic [PH_W-1:0]  phase_q;
    logic             lamp_q;
    logic [PH_W-1:0]  age_q;
    logic             sent_q;

    t_blink_out       blink_due[$];
    int               mismatches;
    int               results_seen;

    task automatic note_mismatch(input string msg);
        if (mismatches < 10) begin
            $display("%0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic t_blink_out step_blink(input logic [EL_W-1:0] el,
                                              input logic pres,
                                              input logic [HDR_W-1:0] hdr,
                                              input logic [RXP_W-1:0] rxp);
        t_blink_out res;
        int         cyc;
        int         total;
        int         age;
        int         ph;
        int         half;
        int         d;
        int         np;
        logic       lamp;
        logic       sent;

        res  = '0;
        cyc  = (cycle_reg == '0) ? int'(CYC_ZERO_LEN) : int'(cycle_reg);
        age  = int'(age_q);
        lamp = lamp_q;
        sent = sent_q;

        if (el != '0) begin
            age = age + int'(el);
            if (age > int'(AGE_MAX)) begin
                age = int'(AGE_MAX);
            end
        end
        total = int'(phase_q) + int'(el);
        ph    = total % cyc;
        if (total >= cyc) begin
            lamp = 1'b1;
            age  = 0;
            sent = 1'b0;
        end

        if (lamp) begin
            if (age >= int'(lamp_on_reg)) begin
                lamp = 1'b0;
            end
        end else if (ph < int'(lamp_on_reg)) begin
            lamp = 1'b1;
            age  = 0;
        end

        // The window end is not wrapped, so a window past the cycle end is cut short.
        if (!sent && ph >= int'(start_reg) && ph < int'(start_reg) + int'(window_reg)) begin
            res.send_now   = 1'b1;
            res.send_phase = PH_W'((ph + int'(delay_reg)) % cyc);
            sent = 1'b1;
            lamp = 1'b1;
            age  = 0;
        end

        if (pres && hdr == SYNC_HEADER && int'(rxp) < cyc) begin
            half = cyc / 2;
            d    = int'(rxp) - ph;
            if (d > half) begin
                d = d - cyc;
            end
            if (d < -half) begin
                d = d + cyc;
            end
            np = ph + d / (1 << PULL_SHIFT);
            if (np < 0) begin
                np = np + cyc;
            end
            if (np >= cyc) begin
                np = np - cyc;
            end
            ph   = np;
            lamp = 1'b1;
            age  = 0;
        end

        phase_q = PH_W'(ph);
        lamp_q  = lamp;
        age_q   = PH_W'(age);
        sent_q  = sent;

        res.lamp_lit      = lamp;
        res.current_phase = PH_W'(ph);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_blink_out got;
        t_blink_out want;
        logic [31:0] rd_want;

        if (!i_rst_n) begin
            cycle_reg    = RST_CYCLE;
            lamp_on_reg  = RST_LAMP_ON;
            start_reg    = RST_SEND_START;
            window_reg   = RST_SEND_WIN;
            delay_reg    = RST_AIR_DELAY;
            phase_q      = '0;
            lamp_q       = 1'b0;
            age_q        = '0;
            sent_q       = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            blink_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[0], m_axis_tuser, m_axis_tdata[12:1], m_axis_tdata[24:13]};
                if (blink_due.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = blink_due.pop_front();
                    if (got !== want || m_axis_tdata[31:25] !== '0) begin
                        note_mismatch($sformatf({"result %0d: expected lamp %0b send %0b ",
                            "send_phase %0d phase %0d, got lamp %0b send %0b ",
                            "send_phase %0d phase %0d pad %h"}, results_seen,
                            want.lamp_lit, want.send_now, want.send_phase, want.current_phase,
                            got.lamp_lit, got.send_now, got.send_phase, got.current_phase,
                            m_axis_tdata[31:25]));
                    end
                end
                results_seen++;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                blink_due.push_back(step_blink(s_axis_tdata[7:0], s_axis_tuser,
                                               s_axis_tdata[23:8], s_axis_tdata[39:24]));
            end

            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[ADDR_W-1:2]))
                        REG_CYCLE:      cycle_reg   = pwdata[CFG_W-1:0];
                        REG_LAMP_ON:    lamp_on_reg = pwdata[CFG_W-1:0];
                        REG_SEND_START: start_reg   = pwdata[CFG_W-1:0];
                        REG_SEND_WIN:   window_reg  = pwdata[CFG_W-1:0];
                        REG_AIR_DELAY:  delay_reg   = pwdata[AIR_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[ADDR_W-1:2]))
                        REG_CYCLE:      rd_want = 32'(cycle_reg);
                        REG_LAMP_ON:    rd_want = 32'(lamp_on_reg);
                        REG_SEND_START: rd_want = 32'(start_reg);
                        REG_SEND_WIN:   rd_want = 32'(window_reg);
                        REG_AIR_DELAY:  rd_want = 32'(delay_reg);
                        default:        rd_want = '0;
                    endcase
                    if (prdata !== rd_want) begin
                        note_mismatch($sformatf("register read at %0d: expected %h, got %h",
                                                paddr, rd_want, prdata));
                    end
                end
            end
        end

        o_errors  <= mismatches;
        o_pending <= blink_due.size();
    end

endmodule

// ===== test/phase_sync_blink_tracker_tb.sv =====
`timescale 1ns / 1ps

module phase_sync_blink_tracker_tb;
    import psbt_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int errors;
    int pending;
    bit hold_req;
    bit hold_done;
    bit no_idle;
    int burst_left;
    int cur_cyc;

    phase_sync_blink_tracker i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    phase_sync_blink_tracker_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #5_000_000;
        $display("phase_sync_blink_tracker_tb: done, errors");
        $finish;
    end

    // The receiver follows its own stall pattern, and holds off for a long stretch on request.
    initial begin : receiver
        int mode;
        int span;
        int k;

        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        mode = 0;
        span = 0;
        k    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 120);
                end
                span--;
                k++;
                case (mode)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = ($urandom_range(0, 9) < 7);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (k % 3 == 0);
                endcase
            end
        end
    end

    task automatic offer(input logic [EL_W-1:0] el, input logic pres,
                         input logic [HDR_W-1:0] hdr, input logic [RXP_W-1:0] rxp);
        int gap;

        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!no_idle && $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 8);
            end
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {rxp, hdr, el};
        s_axis_tuser  = pres;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = ADDR_W'(4 * int'(idx));
        pwdata  = wr ? val : '0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_all();
        t_reg_idx ridx;

        ridx = ridx.first();
        repeat (ridx.num()) begin
            apb_access(1'b0, ridx, '0);
            ridx = ridx.next();
        end
    endtask

    task automatic load_config(input logic [CFG_W-1:0] cyc, input logic [CFG_W-1:0] on,
                               input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] win,
                               input logic [AIR_W-1:0] air);
        settle();
        apb_access(1'b1, REG_CYCLE, 32'(cyc));
        apb_access(1'b1, REG_LAMP_ON, 32'(on));
        apb_access(1'b1, REG_SEND_START, 32'(start));
        apb_access(1'b1, REG_SEND_WIN, 32'(win));
        apb_access(1'b1, REG_AIR_DELAY, 32'(air));
        read_all();
        cur_cyc = (cyc == '0) ? int'(CYC_ZERO_LEN) : int'(cyc);
    endtask

    // Mostly plain loop passes and good sync packets; the rest are malformed packets.
    task automatic rand_item();
        int              kind;
        int              r;
        logic [EL_W-1:0] el;
        logic            pres;
        logic [HDR_W-1:0] hdr;
        logic [RXP_W-1:0] rxp;

        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            el = '0;
        end else if (kind < 5) begin
            el = EL_W'($urandom_range(1, 15));
        end else if (kind < 9) begin
            el = EL_W'($urandom_range(16, 127));
        end else begin
            el = EL_W'($urandom_range(128, 255));
        end
        hdr  = HDR_W'($urandom);
        rxp  = RXP_W'($urandom);
        pres = 1'b0;
        r    = $urandom_range(0, 99);
        if (r >= 65) begin
            pres = 1'b1;
            if (r < 88) begin
                hdr = SYNC_HEADER;
                rxp = RXP_W'($urandom_range(0, cur_cyc - 1));
            end else if (r < 94) begin
                hdr = SYNC_HEADER;
                rxp = RXP_W'($urandom_range(cur_cyc, 65535));
            end
        end else if (r >= 60) begin
            hdr = SYNC_HEADER;
            rxp = RXP_W'($urandom_range(0, cur_cyc - 1));
        end
        offer(el, pres, hdr, rxp);
    endtask

    initial begin : stimulus
        int              c;
        logic [CFG_W-1:0] cyc_w;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_req      = 1'b0;
        no_idle       = 1'b0;
        burst_left    = 0;
        cur_cyc       = int'(RST_CYCLE);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        read_all();

        offer(8'd0, 1'b0, '0, '0);
        offer(8'd255, 1'b0, 16'hFFFF, 16'hFFFF);
        offer(8'd195, 1'b0, '0, '0);
        offer(8'd10, 1'b1, SYNC_HEADER, 16'd899);
        offer(8'd255, 1'b1, 16'h55AA, 16'd100);
        offer(8'd1, 1'b1, SYNC_HEADER, 16'd900);
        // A pull that lands below zero and one that lands past the cycle end.
        offer(8'd100, 1'b1, SYNC_HEADER, 16'd800);
        offer(8'd5, 1'b1, SYNC_HEADER, 16'd100);
        offer(8'd6, 1'b0, SYNC_HEADER, 16'd10);
        offer(8'd0, 1'b1, 16'hFFFF, 16'hFFFF);
        offer(8'd0, 1'b1, 16'h0000, 16'h0000);
        offer(8'd255, 1'b0, '0, '0);
        offer(8'd255, 1'b0, '0, '0);
        offer(8'd200, 1'b0, '0, '0);
        // Shorten the cycle below the current phase, then step with no elapsed time.
        settle();
        apb_access(1'b1, REG_CYCLE, 32'd256);
        cur_cyc = 256;
        offer(8'd0, 1'b0, '0, '0);
        offer(8'd255, 1'b1, SYNC_HEADER, 16'd255);
        offer(8'd255, 1'b1, SYNC_HEADER, 16'd0);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: load_config(12'd256, 12'd1, 12'd0, 12'd1, 8'd255);
                1: load_config(12'd0, 12'd4095, 12'd4095, 12'd4095, 8'd0);
                2: load_config(12'd4095, 12'd2000, 12'd100, 12'd4095, 8'd200);
                3: load_config(RST_CYCLE, RST_LAMP_ON, RST_SEND_START, RST_SEND_WIN,
                               RST_AIR_DELAY);
                default: begin
                    cyc_w = ($urandom_range(0, 7) == 0) ? '0 :
                            CFG_W'($urandom_range(256, 4095));
                    c = (cyc_w == '0) ? int'(CYC_ZERO_LEN) : int'(cyc_w);
                    load_config(cyc_w, CFG_W'($urandom_range(1, 400)),
                                CFG_W'($urandom_range(0, c - 1)),
                                CFG_W'($urandom_range(1, 300)),
                                AIR_W'($urandom_range(0, 255)));
                end
            endcase
            if (p == 4) begin
                hold_req = 1'b1;
                no_idle  = 1'b1;
            end
            repeat (50) rand_item();
            no_idle = 1'b0;
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("phase_sync_blink_tracker_tb: done, clean");
        end else begin
            $display("phase_sync_blink_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/psbt_pkg.sv
src/phase_sync_blink_tracker.sv
src/psbt_checker.sv
test/phase_sync_blink_tracker_checker.sv
test/phase_sync_blink_tracker_tb.sv
